FILE: rtl/ppds_pkg.sv
`default_nettype none
package ppds_pkg;

   // Field and datapath widths
   localparam int RATE_W           = 32;
   localparam int DIV_W            = 3;
   localparam int PROD_W           = 2 * DIV_W;
   localparam int REM_W            = PROD_W;
   localparam int NUM_W            = RATE_W + 1;
   localparam int DIV_STEPS        = NUM_W;
   localparam int CNT_W            = $clog2(DIV_STEPS);
   localparam int MAX_POST_DIV_DEF = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic start_div;
      logic step_div;
      logic seed_eval;
      logic try_eval;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic exact;
      logic last_pair;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/pll_post_divider_search.sv
`default_nettype none
// Post-divider search: for each request beat (target rate, source rate) the block
// returns the divider pair (first, second), first from 1 to MAX_POST_DIV and second
// never above first, whose rounded quotient source/(first*second) is nearest the
// target; an exact pair try ends the search at once and an earlier pair wins a tie.
// One item at a time is in work: a seed try at (MAX,MAX) and then up to
// MAX*(MAX+1)/2 pair tries, each made of setup, 33 one-bit restoring division
// steps in a shared serial divider, and compare. The result sits in an output
// register, so the next request is taken while a result waits.
module pll_post_divider_search
   import ppds_pkg::*;
#(
   parameter int MAX_POST_DIV = MAX_POST_DIV_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [RATE_W-1:0] req_target_rate,
   input  wire logic [RATE_W-1:0] req_source_rate,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DIV_W-1:0]  rsp_first_divider,
   output logic      [DIV_W-1:0]  rsp_second_divider
);

   cmd_type    cmd;
   status_type status;

   ppds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ppds_datapath #(
      .MAX_POST_DIV (MAX_POST_DIV)
   ) u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_target_rate    (req_target_rate),
      .req_source_rate    (req_source_rate),
      .rsp_first_divider  (rsp_first_divider),
      .rsp_second_divider (rsp_second_divider)
   );

endmodule
`default_nettype wire

FILE: rtl/ppds_datapath.sv
`default_nettype none
module ppds_datapath
   import ppds_pkg::*;
#(
   parameter int MAX_POST_DIV = MAX_POST_DIV_DEF
) (
   input  wire logic              clock,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [RATE_W-1:0] req_target_rate,
   input  wire logic [RATE_W-1:0] req_source_rate,
   output logic      [DIV_W-1:0]  rsp_first_divider,
   output logic      [DIV_W-1:0]  rsp_second_divider
);

   localparam logic [DIV_W-1:0] MAX_DIV = DIV_W'(MAX_POST_DIV);
   localparam logic [DIV_W-1:0] ONE_DIV = DIV_W'(1);

   logic [RATE_W-1:0] target_ff, target_in;
   logic [RATE_W-1:0] source_ff, source_in;
   logic [DIV_W-1:0]  cand_a_ff, cand_a_in;
   logic [DIV_W-1:0]  cand_b_ff, cand_b_in;
   logic [DIV_W-1:0]  best_a_ff, best_a_in;
   logic [DIV_W-1:0]  best_b_ff, best_b_in;
   logic [NUM_W-1:0]  best_err_ff, best_err_in;
   logic [PROD_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]  rsp_a_ff, rsp_a_in;
   logic [DIV_W-1:0]  rsp_b_ff, rsp_b_in;

   logic [PROD_W-1:0] prod;
   logic [REM_W:0]    shift;
   logic              fits;
   logic [NUM_W-1:0]  target_ext;
   logic [NUM_W-1:0]  err;

   // Form the candidate product, the shifted partial remainder, its fit and the error
   always_comb begin
      prod       = PROD_W'(cand_a_ff) * PROD_W'(cand_b_ff);
      shift      = {rem_ff, num_ff[NUM_W-1]};
      fits       = (shift >= {1'b0, den_ff});
      target_ext = {1'b0, target_ff};
      err        = (quot_ff > target_ext) ? (quot_ff - target_ext) : (target_ext - quot_ff);
   end

   // Report match and end of the pair sweep
   always_comb begin
      status.exact     = (quot_ff == target_ext);
      status.last_pair = (cand_a_ff == MAX_DIV) && (cand_b_ff == MAX_DIV);
   end

   // Next values of the datapath registers
   always_comb begin
      target_in   = target_ff;
      source_in   = source_ff;
      cand_a_in   = cand_a_ff;
      cand_b_in   = cand_b_ff;
      best_a_in   = best_a_ff;
      best_b_in   = best_b_ff;
      best_err_in = best_err_ff;
      den_in      = den_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      rsp_a_in    = rsp_a_ff;
      rsp_b_in    = rsp_b_ff;

      // capture the beat and seed with the largest pair
      if (cmd.load_item) begin
         target_in = req_target_rate;
         source_in = req_source_rate;
         cand_a_in = MAX_DIV;
         cand_b_in = MAX_DIV;
      end

      // set up a rounded division by the pair product
      if (cmd.start_div) begin
         den_in  = prod;
         num_in  = {1'b0, source_ff} + NUM_W'(prod >> 1);
         rem_in  = '0;
         quot_in = '0;
      end

      // one restoring division step
      if (cmd.step_div) begin
         rem_in  = fits ? REM_W'(shift - {1'b0, den_ff}) : shift[REM_W-1:0];
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], fits};
      end

      // seed error, then restart the sweep at the smallest pair
      if (cmd.seed_eval) begin
         best_a_in   = cand_a_ff;
         best_b_in   = cand_b_ff;
         best_err_in = err;
         cand_a_in   = ONE_DIV;
         cand_b_in   = ONE_DIV;
      end

      // keep an exact or strictly better pair, then advance
      if (cmd.try_eval) begin
         if (status.exact || (err < best_err_ff)) begin
            best_a_in   = cand_a_ff;
            best_b_in   = cand_b_ff;
            best_err_in = err;
         end
         if (cand_b_ff == cand_a_ff) begin
            cand_a_in = cand_a_ff + ONE_DIV;
            cand_b_in = ONE_DIV;
         end else begin
            cand_b_in = cand_b_ff + ONE_DIV;
         end
      end

      // hand the best pair to the output register
      if (cmd.load_rsp) begin
         rsp_a_in = best_a_ff;
         rsp_b_in = best_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      source_ff   <= source_in;
      cand_a_ff   <= cand_a_in;
      cand_b_ff   <= cand_b_in;
      best_a_ff   <= best_a_in;
      best_b_ff   <= best_b_in;
      best_err_ff <= best_err_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
   end

   assign rsp_first_divider  = rsp_a_ff;
   assign rsp_second_divider = rsp_b_ff;

endmodule
`default_nettype wire

FILE: rtl/ppds_controller.sv
`default_nettype none
module ppds_controller
   import ppds_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             seed_ff, seed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             div_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_START;
         ST_START:  state_in = ST_DIV;
         ST_DIV:    if (div_last) state_in = ST_EVAL;
         ST_EVAL: begin
            if (seed_ff) begin
               state_in = ST_START;
            end else if (status.exact || status.last_pair) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_START;
            end
         end
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_START:  cmd.start_div = 1'b1;
         ST_DIV:    cmd.step_div  = 1'b1;
         ST_EVAL: begin
            cmd.seed_eval = seed_ff;
            cmd.try_eval  = !seed_ff;
         end
         ST_FINISH: cmd.load_rsp = slot_free;
         default:   cmd = '0;
      endcase
   end

   // Step counter, seed flag and output beat flag
   always_comb begin
      cnt_in       = (state_ff == ST_DIV && !div_last) ? cnt_ff + CNT_W'(1) : '0;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_item) seed_in = 1'b1;
      if (cmd.seed_eval) seed_in = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The step counter only runs while dividing
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (cnt_ff == '0))
      else $error("division step counter active outside division");

   // An accepted beat always starts the seed division
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_START && seed_ff))
      else $error("accepted beat did not start the seed division");

   // A result appears only out of the finish state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result beat raised outside the finish state");

endmodule
`default_nettype wire

FILE: tb/pll_post_divider_search_tb.sv
`default_nettype none
module pll_post_divider_search_tb
   import ppds_pkg::*;
;

   localparam int unsigned MAX_DIV     = MAX_POST_DIV_DEF;
   localparam int unsigned QUIET_LIMIT = 20000;
   localparam int unsigned N_DIRECTED  = 21;
   localparam int unsigned N_RANDOM    = 560;
   localparam int unsigned DRAIN_WAIT  = 1100;
   localparam logic        TYPED       = 1'b1;
   localparam logic        PREDICTED   = 1'b0;

   typedef struct packed {
      logic [DIV_W-1:0] first_div;
      logic [DIV_W-1:0] second_div;
   } div_pair_type;

   typedef struct packed {
      logic [RATE_W-1:0] target;
      logic [RATE_W-1:0] source;
      logic              typed;
      div_pair_type      pair;
   } rate_row_type;

   logic              clock              = 1'b0;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_ready;
   logic [RATE_W-1:0] req_target_rate    = '0;
   logic [RATE_W-1:0] req_source_rate    = '0;
   logic              rsp_valid;
   logic              rsp_ready          = 1'b0;
   logic [DIV_W-1:0]  rsp_first_divider;
   logic [DIV_W-1:0]  rsp_second_divider;

   div_pair_type pair_q[$];
   rate_row_type dir_rows[0:N_DIRECTED-1];
   bit           calm = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  checked = 0;
   int unsigned  sent = 0;
   int unsigned  quiet_cycles = 0;

   pll_post_divider_search u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_rate    (req_target_rate),
      .req_source_rate    (req_source_rate),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_divider  (rsp_first_divider),
      .rsp_second_divider (rsp_second_divider)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Round-to-nearest quotient at full width, so the rounding add never wraps
   function automatic logic [63:0] rounded_quot(logic [RATE_W-1:0] num, int unsigned den);
      return (64'(num) + 64'(den / 2)) / 64'(den);
   endfunction

   function automatic logic [63:0] rate_error(logic [63:0] quot, logic [RATE_W-1:0] target);
      return (quot > 64'(target)) ? quot - 64'(target) : 64'(target) - quot;
   endfunction

   // Seed with (MAX,MAX), then walk the pairs; exact hit stops, strict improvement wins
   function automatic div_pair_type best_divider_pair(logic [RATE_W-1:0] target,
                                                      logic [RATE_W-1:0] source);
      div_pair_type best;
      logic [63:0]  best_err;
      logic [63:0]  quot;
      logic         found;
      best.first_div  = DIV_W'(MAX_DIV);
      best.second_div = DIV_W'(MAX_DIV);
      best_err = rate_error(rounded_quot(source, MAX_DIV * MAX_DIV), target);
      found = 1'b0;
      for (int unsigned a = 1; a <= MAX_DIV && !found; a++) begin
         for (int unsigned b = 1; b <= a && !found; b++) begin
            quot = rounded_quot(source, a * b);
            if (quot == 64'(target)) begin
               best.first_div  = DIV_W'(a);
               best.second_div = DIV_W'(b);
               found = 1'b1;
            end else if (rate_error(quot, target) < best_err) begin
               best.first_div  = DIV_W'(a);
               best.second_div = DIV_W'(b);
               best_err = rate_error(quot, target);
            end
         end
      end
      return best;
   endfunction

   // Mostly no gap or a short one, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(21, 1200);
   endfunction

   // Drive one request beat and hold it until accepted, then queue its expected pair
   task automatic send_request(input logic [RATE_W-1:0] target, input logic [RATE_W-1:0] source,
                               input logic typed, input div_pair_type typed_pair);
      int unsigned gap;
      gap = calm ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_target_rate <= target;
      req_source_rate <= source;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pair_q.push_back(typed ? typed_pair : best_divider_pair(target, source));
      sent++;
   endtask

   // Stall the result side at random, except during calm stretches
   initial begin : rsp_stall
      int unsigned n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = calm ? 0 : idle_gap();
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Check each result beat against the oldest expected pair
   always @(posedge clock) begin : rsp_check
      div_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pair_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: first=%0d second=%0d",
                        rsp_first_divider, rsp_second_divider);
         end else begin
            want = pair_q.pop_front();
            checked++;
            if (rsp_first_divider !== want.first_div ||
                rsp_second_divider !== want.second_div) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d mismatch: expected (%0d,%0d), got (%0d,%0d)",
                           checked, want.first_div, want.second_div,
                           rsp_first_divider, rsp_second_divider);
            end
         end
      end
   end

   // Count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("no beat for %0d cycles, %0d results still expected", QUIET_LIMIT,
               pair_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [RATE_W-1:0] target;
      logic [RATE_W-1:0] source;
      logic [63:0]       quot;
      int unsigned       kind;
      int unsigned       a;
      int unsigned       b;

      dir_rows = '{
         // zero source with zero target: every try exact at 0, first pair wins
         '{32'd0,          32'd0,          TYPED,     '{3'd1, 3'd1}},
         // zero source: all errors tie, seed pair stays
         '{32'd5,          32'd0,          TYPED,     '{3'd7, 3'd7}},
         '{32'hFFFF_FFFF,  32'd0,          TYPED,     '{3'd7, 3'd7}},
         // zero target: smallest rounded quotient
         '{32'd0,          32'hFFFF_FFFF,  PREDICTED, '{3'd0, 3'd0}},
         '{32'd0,          32'd1,          PREDICTED, '{3'd0, 3'd0}},
         '{32'd0,          32'd3,          PREDICTED, '{3'd0, 3'd0}},
         // equal rates, full scale and below, exact at (1,1)
         '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  TYPED,     '{3'd1, 3'd1}},
         '{32'd1000,       32'd1000,       TYPED,     '{3'd1, 3'd1}},
         '{32'd1,          32'd1,          TYPED,     '{3'd1, 3'd1}},
         // seed pair exact, met again at the end of the walk
         '{32'd100,        32'd4900,       TYPED,     '{3'd7, 3'd7}},
         '{32'd200,        32'd9800,       PREDICTED, '{3'd0, 3'd0}},
         // rounding add past 32 bits
         '{32'h8000_0000,  32'hFFFF_FFFF,  PREDICTED, '{3'd0, 3'd0}},
         '{32'h5555_5555,  32'hFFFF_FFFF,  PREDICTED, '{3'd0, 3'd0}},
         '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  PREDICTED, '{3'd0, 3'd0}},
         '{32'h7FFF_FFFF,  32'hFFFF_FFFF,  PREDICTED, '{3'd0, 3'd0}},
         // bit patterns and assorted ratios
         '{32'hAAAA_AAAA,  32'h5555_5555,  PREDICTED, '{3'd0, 3'd0}},
         '{32'h5555_5555,  32'hAAAA_AAAA,  PREDICTED, '{3'd0, 3'd0}},
         '{32'd1000000,    32'd12000000,   PREDICTED, '{3'd0, 3'd0}},
         '{32'd999,        32'd49000,      PREDICTED, '{3'd0, 3'd0}},
         '{32'd12345678,   32'd7,          PREDICTED, '{3'd0, 3'd0}},
         '{32'd2,          32'd7,          PREDICTED, '{3'd0, 3'd0}}
      };

      // Hold reset, then release it
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      for (int unsigned i = 0; i < N_DIRECTED; i++)
         send_request(dir_rows[i].target, dir_rows[i].source, dir_rows[i].typed,
                      dir_rows[i].pair);

      // Hold off the sender until every result is back
      req_valid <= 1'b0;
      while (pair_q.size() != 0) @(posedge clock);

      // Random rates, mostly aimed at or near some pair's quotient
      for (int unsigned i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 100 && i < 160);
         if (i == 300) begin
            req_valid <= 1'b0;
            while (pair_q.size() != 0) @(posedge clock);
         end
         kind   = $urandom_range(0, 99);
         a      = $urandom_range(1, MAX_DIV);
         b      = $urandom_range(1, a);
         source = $urandom;
         if (kind >= 80 && kind < 90)
            source = RATE_W'($urandom_range(0, 200));
         else if (kind >= 90)
            source = 32'hFFFF_FFFF - RATE_W'($urandom_range(0, 63));
         quot = rounded_quot(source, a * b);
         if (kind < 35)
            target = RATE_W'(quot);
         else if (kind < 65)
            target = RATE_W'(quot) + RATE_W'($urandom_range(0, 6)) - RATE_W'(3);
         else if (kind < 80)
            target = $urandom;
         else if (kind < 90)
            target = RATE_W'($urandom_range(0, 60));
         else
            target = ($urandom_range(0, 1) != 0) ? RATE_W'(quot) : $urandom;
         send_request(target, source, PREDICTED, '{3'd0, 3'd0});
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain, then watch for stray results
      while (pair_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d requests (%0d directed, %0d random), checked %0d results",
               sent, N_DIRECTED, N_RANDOM, checked);
      $display("stimulus mixed exact hits, near misses, zero and full-scale rates; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pair_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
